### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon parity package
// Widths, register-file slots, the micro-op table and control structs.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int OPW         = 2 * COORD_WIDTH + 8;
    localparam int ACCW        = 2 * OPW;
    localparam int HALF        = OPW / 2;
    localparam int HIW         = OPW - HALF;
    localparam int NUM_SLOTS   = 22;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int NUM_LOAD    = 12;
    localparam int LOAD_W      = $clog2(NUM_LOAD);
    localparam int NUM_OPS     = 29;
    localparam int STEP_W      = $clog2(NUM_OPS);

    typedef enum logic [SLOT_W-1:0] {
        SL_V0X, SL_V0Y, SL_V0Z,
        SL_V1X, SL_V1Y, SL_V1Z,
        SL_EX,  SL_EY,  SL_EZ,
        SL_UX,  SL_UY,  SL_UZ,
        SL_EE,
        SL_C0X, SL_C0Y, SL_C0Z,
        SL_C1X, SL_C1Y, SL_C1Z,
        SL_DVU, SL_DEU, SL_DEV
    } slot_t;

    typedef enum logic [1:0] {CHK_NONE, CHK_EE_ZERO, CHK_CROSS, CHK_FWD} check_t;

    typedef enum logic [1:0] {PH_NONE, PH_LO, PH_HI, PH_WB} phase_t;

    typedef struct packed {
        slot_t  a;
        slot_t  b;
        logic   neg;
        logic   clr;
        logic   store;
        slot_t  dest;
        check_t chk;
    } op_t;

    typedef struct packed {
        logic              capture;
        logic              first_item;
        logic              set_prev;
        logic              set_ray;
        logic              init_parity;
        logic              load_we;
        logic [LOAD_W-1:0] load_idx;
        phase_t            phase;
        logic [STEP_W-1:0] step;
        logic              edge_sel;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic abort;
        logic parity;
    } status_t;

    function automatic op_t mk(input slot_t a, input slot_t b, input logic neg,
                               input logic clr, input logic store, input slot_t dest,
                               input check_t chk);
        op_t o;
        o.a     = a;
        o.b     = b;
        o.neg   = neg;
        o.clr   = clr;
        o.store = store;
        o.dest  = dest;
        o.chk   = chk;
        return o;
    endfunction

    // Multiply-accumulate program for one edge test.
    function automatic op_t op_at(input logic [STEP_W-1:0] step);
        op_t o;
        case (step)
            STEP_W'(0):  o = mk(SL_EX,  SL_EX,  1'b0, 1'b1, 1'b0, SL_EE,  CHK_NONE);
            STEP_W'(1):  o = mk(SL_EY,  SL_EY,  1'b0, 1'b0, 1'b0, SL_EE,  CHK_NONE);
            STEP_W'(2):  o = mk(SL_EZ,  SL_EZ,  1'b0, 1'b0, 1'b1, SL_EE,  CHK_EE_ZERO);
            STEP_W'(3):  o = mk(SL_V0Y, SL_UZ,  1'b0, 1'b1, 1'b0, SL_C0X, CHK_NONE);
            STEP_W'(4):  o = mk(SL_V0Z, SL_UY,  1'b1, 1'b0, 1'b1, SL_C0X, CHK_NONE);
            STEP_W'(5):  o = mk(SL_V0Z, SL_UX,  1'b0, 1'b1, 1'b0, SL_C0Y, CHK_NONE);
            STEP_W'(6):  o = mk(SL_V0X, SL_UZ,  1'b1, 1'b0, 1'b1, SL_C0Y, CHK_NONE);
            STEP_W'(7):  o = mk(SL_V0X, SL_UY,  1'b0, 1'b1, 1'b0, SL_C0Z, CHK_NONE);
            STEP_W'(8):  o = mk(SL_V0Y, SL_UX,  1'b1, 1'b0, 1'b1, SL_C0Z, CHK_NONE);
            STEP_W'(9):  o = mk(SL_UY,  SL_V1Z, 1'b0, 1'b1, 1'b0, SL_C1X, CHK_NONE);
            STEP_W'(10): o = mk(SL_UZ,  SL_V1Y, 1'b1, 1'b0, 1'b1, SL_C1X, CHK_NONE);
            STEP_W'(11): o = mk(SL_UZ,  SL_V1X, 1'b0, 1'b1, 1'b0, SL_C1Y, CHK_NONE);
            STEP_W'(12): o = mk(SL_UX,  SL_V1Z, 1'b1, 1'b0, 1'b1, SL_C1Y, CHK_NONE);
            STEP_W'(13): o = mk(SL_UX,  SL_V1Y, 1'b0, 1'b1, 1'b0, SL_C1Z, CHK_NONE);
            STEP_W'(14): o = mk(SL_UY,  SL_V1X, 1'b1, 1'b0, 1'b1, SL_C1Z, CHK_NONE);
            STEP_W'(15): o = mk(SL_C0X, SL_C1X, 1'b0, 1'b1, 1'b0, SL_EE,  CHK_NONE);
            STEP_W'(16): o = mk(SL_C0Y, SL_C1Y, 1'b0, 1'b0, 1'b0, SL_EE,  CHK_NONE);
            STEP_W'(17): o = mk(SL_C0Z, SL_C1Z, 1'b0, 1'b0, 1'b0, SL_EE,  CHK_CROSS);
            STEP_W'(18): o = mk(SL_V0X, SL_UX,  1'b0, 1'b1, 1'b0, SL_DVU, CHK_NONE);
            STEP_W'(19): o = mk(SL_V0Y, SL_UY,  1'b0, 1'b0, 1'b0, SL_DVU, CHK_NONE);
            STEP_W'(20): o = mk(SL_V0Z, SL_UZ,  1'b0, 1'b0, 1'b1, SL_DVU, CHK_NONE);
            STEP_W'(21): o = mk(SL_EX,  SL_UX,  1'b0, 1'b1, 1'b0, SL_DEU, CHK_NONE);
            STEP_W'(22): o = mk(SL_EY,  SL_UY,  1'b0, 1'b0, 1'b0, SL_DEU, CHK_NONE);
            STEP_W'(23): o = mk(SL_EZ,  SL_UZ,  1'b0, 1'b0, 1'b1, SL_DEU, CHK_NONE);
            STEP_W'(24): o = mk(SL_EX,  SL_V0X, 1'b0, 1'b1, 1'b0, SL_DEV, CHK_NONE);
            STEP_W'(25): o = mk(SL_EY,  SL_V0Y, 1'b0, 1'b0, 1'b0, SL_DEV, CHK_NONE);
            STEP_W'(26): o = mk(SL_EZ,  SL_V0Z, 1'b0, 1'b0, 1'b1, SL_DEV, CHK_NONE);
            STEP_W'(27): o = mk(SL_EE,  SL_DVU, 1'b0, 1'b1, 1'b0, SL_EE,  CHK_NONE);
            STEP_W'(28): o = mk(SL_DEV, SL_DEU, 1'b1, 1'b0, 1'b0, SL_EE,  CHK_FWD);
            default:     o = mk(SL_V0X, SL_V0X, 1'b0, 1'b1, 1'b0, SL_EE,  CHK_NONE);
        endcase
        return o;
    endfunction

endpackage

### rtl/pip_if.sv
// ----------------------------------------------------------------------------
// Point-in-polygon channel interfaces
// Vertex input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_vertex_if
    import pip_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic signed [COORD_WIDTH-1:0] query_z;
    logic                          last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, query_x, query_y, query_z,
                    last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, query_x, query_y, query_z,
                    last_vertex, output ready);
endinterface

interface pip_result_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic too_few_vertices;

    modport source (output valid, inside_res, too_few_vertices, input ready);
    modport sink   (input valid, inside_res, too_few_vertices, output ready);
endinterface

### rtl/pip_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/pip_datapath.sv
// ----------------------------------------------------------------------------
// Point-in-polygon datapath
// Vertex registers, operand RAM, shared split multiplier and accumulator.
// ----------------------------------------------------------------------------
module pip_datapath
    import pip_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_z,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,
    input  logic                          last_vertex,
    output status_t                       status
);

    logic signed [COORD_WIDTH-1:0] cur_reg   [3];
    logic signed [COORD_WIDTH-1:0] first_reg [3];
    logic signed [COORD_WIDTH-1:0] prev_reg  [3];
    logic signed [COORD_WIDTH-1:0] query_reg [3];
    logic signed [COORD_WIDTH+1:0] ray_reg   [3];
    logic                          last_reg;
    logic                          parity_reg;
    logic signed [ACCW-1:0]        acc_reg;
    logic signed [ACCW-1:0]        acc_next;

    logic signed [COORD_WIDTH-1:0] in_v [3];
    logic signed [COORD_WIDTH-1:0] pa [3];
    logic signed [COORD_WIDTH-1:0] pb [3];
    logic signed [OPW-1:0]         v0 [3];
    logic signed [OPW-1:0]         v1 [3];
    logic signed [OPW-1:0]         ed [3];
    logic signed [OPW-1:0]         uu [3];
    logic signed [COORD_WIDTH+1:0] ray_new [3];
    logic                          same;

    op_t                    op;
    slot_t                  load_slot;
    logic [OPW-1:0]         load_val;
    logic                   we;
    slot_t                  waddr;
    logic [OPW-1:0]         wdata;
    logic [OPW-1:0]         rdata_a;
    logic [OPW-1:0]         rdata_b;
    logic signed [OPW-1:0]  a_val;
    logic signed [HALF:0]   b_lo;
    logic signed [HIW-1:0]  b_hi;
    logic signed [OPW+HALF:0] p_lo;
    logic signed [OPW+HIW-1:0] p_hi;
    logic signed [ACCW-1:0] part;
    logic signed [ACCW-1:0] base;
    logic                   acc_zero;
    logic                   acc_pos;

    assign in_v[0] = vertex_x;
    assign in_v[1] = vertex_y;
    assign in_v[2] = vertex_z;

    always_comb
    begin
        same = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = cmd.edge_sel ? cur_reg[k] : prev_reg[k];
            pb[k] = cmd.edge_sel ? first_reg[k] : cur_reg[k];
            v0[k] = OPW'($signed({pa[k][COORD_WIDTH-1], pa[k]})
                    - $signed({query_reg[k][COORD_WIDTH-1], query_reg[k]}));
            v1[k] = OPW'($signed({pb[k][COORD_WIDTH-1], pb[k]})
                    - $signed({query_reg[k][COORD_WIDTH-1], query_reg[k]}));
            ed[k] = OPW'($signed({pb[k][COORD_WIDTH-1], pb[k]})
                    - $signed({pa[k][COORD_WIDTH-1], pa[k]}));
            uu[k] = OPW'(ray_reg[k]);
            ray_new[k] = (COORD_WIDTH+2)'(first_reg[k]) + (COORD_WIDTH+2)'(cur_reg[k])
                         - ((COORD_WIDTH+2)'(query_reg[k]) <<< 1);
            if (cur_reg[k] != first_reg[k])
            begin
                same = 1'b0;
            end
        end
    end

    assign load_slot = slot_t'(SLOT_W'(cmd.load_idx));

    always_comb
    begin
        case (load_slot)
            SL_V0X:  load_val = v0[0];
            SL_V0Y:  load_val = v0[1];
            SL_V0Z:  load_val = v0[2];
            SL_V1X:  load_val = v1[0];
            SL_V1Y:  load_val = v1[1];
            SL_V1Z:  load_val = v1[2];
            SL_EX:   load_val = ed[0];
            SL_EY:   load_val = ed[1];
            SL_EZ:   load_val = ed[2];
            SL_UX:   load_val = uu[0];
            SL_UY:   load_val = uu[1];
            SL_UZ:   load_val = uu[2];
            default: load_val = '0;
        endcase
    end

    assign op    = op_at(cmd.step);
    assign we    = cmd.load_we || (cmd.phase == PH_WB && op.store);
    assign waddr = cmd.load_we ? load_slot : op.dest;
    assign wdata = cmd.load_we ? load_val : acc_reg[OPW-1:0];

    pip_ram #(
        .WIDTH (OPW),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (op.a),
        .raddr_b (op.b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign a_val = $signed(rdata_a);
    assign b_lo  = $signed({1'b0, rdata_b[HALF-1:0]});
    assign b_hi  = $signed(rdata_b[OPW-1:HALF]);
    assign p_lo  = a_val * b_lo;
    assign p_hi  = a_val * b_hi;

    always_comb
    begin
        if (cmd.phase == PH_LO)
        begin
            part = ACCW'(p_lo);
            base = op.clr ? '0 : acc_reg;
        end
        else
        begin
            part = ACCW'(p_hi) <<< HALF;
            base = acc_reg;
        end
        acc_next = op.neg ? (base - part) : (base + part);
    end

    assign acc_zero = (acc_reg == '0);
    assign acc_pos  = !acc_reg[ACCW-1] && !acc_zero;

    always_comb
    begin
        status.last   = last_reg;
        status.parity = parity_reg;
        status.abort  = 1'b0;
        if (cmd.phase == PH_WB)
        begin
            case (op.chk)
                CHK_EE_ZERO: status.abort = acc_zero;
                CHK_CROSS:   status.abort = !acc_pos;
                default:     status.abort = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cur_reg[k] <= in_v[k];
                if (cmd.first_item)
                begin
                    first_reg[k] <= in_v[k];
                end
            end
            if (cmd.first_item)
            begin
                query_reg[0] <= query_x;
                query_reg[1] <= query_y;
                query_reg[2] <= query_z;
            end
            last_reg <= last_vertex;
        end
        if (cmd.set_prev)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prev_reg[k] <= cur_reg[k];
            end
        end
        if (cmd.set_ray)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ray_reg[k] <= ray_new[k];
            end
        end
        if (cmd.phase == PH_LO || cmd.phase == PH_HI)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
        end
        else if (cmd.init_parity)
        begin
            parity_reg <= cmd.set_ray ? !same : 1'b0;
        end
        else if (cmd.phase == PH_WB && op.chk == CHK_FWD && acc_pos)
        begin
            parity_reg <= !parity_reg;
        end
    end

endmodule

### rtl/pip_ctrl.sv
// ----------------------------------------------------------------------------
// Point-in-polygon controller
// Vertex bookkeeping, edge-test sequencing and the result register.
// ----------------------------------------------------------------------------
module pip_ctrl
    import pip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    out_inside,
    output logic    out_few,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_LOAD, ST_READ, ST_LO, ST_HI, ST_WB, ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [1:0]        seen_reg;
    logic [LOAD_W-1:0] load_idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic              edge_sel_reg;
    logic              too_few_reg;
    logic              out_valid_reg;
    logic              out_inside_reg;
    logic              out_few_reg;
    logic              accept;
    logic              done;
    logic              emit_ok;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;
    assign out_few    = out_few_reg;
    assign done       = status.abort || (step_reg == STEP_W'(NUM_OPS - 1));
    assign emit_ok    = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.capture     = accept;
        cmd.first_item  = (seen_reg == 2'd0);
        cmd.set_prev    = (state_reg == ST_DECIDE && seen_reg != 2'd2)
                          || (state_reg == ST_WB && done && !edge_sel_reg);
        cmd.set_ray     = (state_reg == ST_DECIDE && seen_reg == 2'd1);
        cmd.init_parity = (state_reg == ST_DECIDE && seen_reg != 2'd2);
        cmd.load_we     = (state_reg == ST_LOAD);
        cmd.load_idx    = load_idx_reg;
        cmd.step        = step_reg;
        cmd.edge_sel    = edge_sel_reg;
        case (state_reg)
            ST_LO:   cmd.phase = PH_LO;
            ST_HI:   cmd.phase = PH_HI;
            ST_WB:   cmd.phase = PH_WB;
            default: cmd.phase = PH_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seen_reg       <= 2'd0;
            load_idx_reg   <= '0;
            step_reg       <= '0;
            edge_sel_reg   <= 1'b0;
            too_few_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_inside_reg <= 1'b0;
            out_few_reg    <= 1'b0;
        end
        else
        begin
            if (emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    too_few_reg  <= (seen_reg == 2'd0);
                    load_idx_reg <= '0;
                    case (seen_reg)
                        2'd0:
                        begin
                            if (status.last)
                            begin
                                state_reg <= ST_EMIT;
                            end
                            else
                            begin
                                seen_reg  <= 2'd1;
                                state_reg <= ST_IDLE;
                            end
                        end
                        2'd1:
                        begin
                            seen_reg     <= 2'd2;
                            edge_sel_reg <= 1'b1;
                            state_reg    <= status.last ? ST_LOAD : ST_IDLE;
                        end
                        default:
                        begin
                            edge_sel_reg <= 1'b0;
                            state_reg    <= ST_LOAD;
                        end
                    endcase
                end
                ST_LOAD:
                begin
                    if (load_idx_reg == LOAD_W'(NUM_LOAD - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        load_idx_reg <= load_idx_reg + 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LO;
                end
                ST_LO:
                begin
                    state_reg <= ST_HI;
                end
                ST_HI:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    if (!done)
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                    else if (edge_sel_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else if (status.last)
                    begin
                        edge_sel_reg <= 1'b1;
                        load_idx_reg <= '0;
                        state_reg    <= ST_LOAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_inside_reg <= too_few_reg ? 1'b0 : status.parity;
                        out_few_reg    <= too_few_reg;
                        seen_reg       <= 2'd0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DECIDE)
        else $error("accepted item not followed by decode");

    a_hi_after_lo: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HI |-> $past(state_reg == ST_LO))
        else $error("multiply high half without low half");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WB |-> step_reg <= STEP_W'(NUM_OPS - 1))
        else $error("micro-op step out of range");

    a_emit_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && too_few_reg) |-> seen_reg == 2'd0)
        else $error("single-vertex result with vertices counted");

endmodule

### rtl/point_in_polygon_parity.sv
// ----------------------------------------------------------------------------
// Point-in-polygon parity test
// Even-odd crossing test of a query point against a streamed 3D polygon.
// ----------------------------------------------------------------------------
// Each edge test makes 12 operand loads and 29 multiply-accumulate steps,
// each through the read, low-half, high-half and write-back states, on the
// one shared multiplier; a zero-length or non-crossing edge ends early.
// Each vertex after the second runs one edge test, the last one a second
// for the closing edge; no new vertex is taken until that is done. Reset
// clears control state; operand RAM is always written first.
module point_in_polygon_parity
    import pip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pip_vertex_if.sink   vertex,
    pip_result_if.source result
);

    cmd_t    cmd;
    status_t status;

    pip_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vertex.valid),
        .in_ready   (vertex.ready),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_inside (result.inside_res),
        .out_few    (result.too_few_vertices),
        .cmd        (cmd),
        .status     (status)
    );

    pip_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .vertex_x    (vertex.vertex_x),
        .vertex_y    (vertex.vertex_y),
        .vertex_z    (vertex.vertex_z),
        .query_x     (vertex.query_x),
        .query_y     (vertex.query_y),
        .query_z     (vertex.query_z),
        .last_vertex (vertex.last_vertex),
        .status      (status)
    );

endmodule
